// File: rtl/wpst_pkg.sv
// ----------------------------------------------------------------------------
// wpst_pkg: shared types and constants for the waypoint steering block
// Fixed-point widths, the CORDIC arctangent table and register indexes.
// ----------------------------------------------------------------------------
package wpst_pkg;

	// Field widths
	localparam int COORD_W   = 10;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int SQ_W      = 2 * COORD_W;
	localparam int HEAD_W    = 15;
	localparam int SPEED_W   = 10;
	localparam int ANG_W     = 11;
	localparam int TOL_W     = 14;
	localparam int CFG_W     = 14;

	// CORDIC datapath: coordinates prescaled by 2^16, angles in Q24
	localparam int PRESCALE  = 16;
	localparam int XY_W      = 30;
	localparam int Z_W       = 29;
	localparam int ERR_W     = 18;
	localparam int TABLE_LEN = 24;

	localparam logic signed [Z_W-1:0]   PI_Q24     = 29'sd52707179;
	localparam logic signed [ERR_W-1:0] PI_Q12     = 18'sd12868;
	localparam logic signed [ERR_W-1:0] TWO_PI_Q12 = 18'sd25736;
	localparam logic signed [Z_W-1:0]   ROUND_Q12  = 29'sd2048;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_ARRIVE_RADIUS = 2'd0,
		REG_HEADING_TOL   = 2'd1,
		REG_TURN_RATE     = 2'd2,
		REG_DRIVE_SPEED   = 2'd3
	} wpst_reg_t;

	// Data handed from cell to cell along the CORDIC chain
	typedef struct packed {
		logic                     vld;
		logic                     arrived;
		logic                     zero;
		logic signed [HEAD_W-1:0] heading;
		logic signed [XY_W-1:0]   x;
		logic signed [XY_W-1:0]   y;
		logic signed [Z_W-1:0]    z;
	} wpst_cell_t;

	// atan(2^-i) in Q24 radians
	function automatic logic signed [Z_W-1:0] wpst_atan(input int unsigned idx);
		logic signed [Z_W-1:0] a;
		case (idx)
			0:       a = 29'sd13176795;
			1:       a = 29'sd7778716;
			2:       a = 29'sd4110060;
			3:       a = 29'sd2086331;
			4:       a = 29'sd1047214;
			5:       a = 29'sd524117;
			6:       a = 29'sd262123;
			7:       a = 29'sd131069;
			8:       a = 29'sd65536;
			9:       a = 29'sd32768;
			10:      a = 29'sd16384;
			11:      a = 29'sd8192;
			12:      a = 29'sd4096;
			13:      a = 29'sd2048;
			14:      a = 29'sd1024;
			15:      a = 29'sd512;
			16:      a = 29'sd256;
			17:      a = 29'sd128;
			18:      a = 29'sd64;
			19:      a = 29'sd32;
			20:      a = 29'sd16;
			21:      a = 29'sd8;
			22:      a = 29'sd4;
			23:      a = 29'sd2;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// File: rtl/wpst_front.sv
// ----------------------------------------------------------------------------
// wpst_front: distance check and CORDIC pre-rotation
// Clamps the cells to the map, squares the offsets against the arrival
// radius and loads the first CORDIC cell in the right half plane.
// ----------------------------------------------------------------------------
module wpst_front import wpst_pkg::*; #(
	parameter int MAP_DIM = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [COORD_W-1:0]    tgt_row,
	input  logic [COORD_W-1:0]    tgt_col,
	input  logic [COORD_W-1:0]    pose_row,
	input  logic [COORD_W-1:0]    pose_col,
	input  logic signed [HEAD_W-1:0] pose_heading,
	input  logic [COORD_W-1:0]    arrive_radius,
	output wpst_cell_t            cell_out
);

	localparam int MAP_MAX = MAP_DIM - 1;
	localparam int CMP_W   = 18;

	logic [COORD_W-1:0]        gr, gc, pr, pc;
	logic signed [DIFF_W-1:0]  dr, dc;

	logic                      vld_s1;
	logic signed [DIFF_W-1:0]  dr_s1, dc_s1;
	logic [SQ_W-1:0]           drsq_s1, dcsq_s1, rsq_s1;
	logic signed [HEAD_W-1:0]  heading_s1;

	logic                      vld_s2;
	wpst_cell_t                cell_s2;

	logic [SQ_W:0]             dist_sq;
	logic signed [XY_W-1:0]    x_scaled, y_scaled;

	// Saturate coordinates beyond the map edge
	function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] c);
		logic [CMP_W-1:0] wide;
		wide = {{(CMP_W-COORD_W){1'b0}}, c};
		return (wide > CMP_W'(MAP_MAX)) ? COORD_W'(MAP_MAX) : c;
	endfunction

	always_comb begin
		gr = clamp(tgt_row);
		gc = clamp(tgt_col);
		pr = clamp(pose_row);
		pc = clamp(pose_col);
		dr = $signed({1'b0, gr}) - $signed({1'b0, pr});
		dc = $signed({1'b0, gc}) - $signed({1'b0, pc});
	end

	// Stage 1: offsets and their squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dr_s1      <= dr;
			dc_s1      <= dc;
			drsq_s1    <= SQ_W'(dr * dr);
			dcsq_s1    <= SQ_W'(dc * dc);
			rsq_s1     <= SQ_W'(arrive_radius * arrive_radius);
			heading_s1 <= pose_heading;
		end
	end

	// Stage 2: arrival compare and pre-rotation into the right half plane
	always_comb begin
		dist_sq  = {1'b0, drsq_s1} + {1'b0, dcsq_s1};
		x_scaled = {{(XY_W-DIFF_W-PRESCALE){dr_s1[DIFF_W-1]}}, dr_s1, {PRESCALE{1'b0}}};
		y_scaled = {{(XY_W-DIFF_W-PRESCALE){dc_s1[DIFF_W-1]}}, dc_s1, {PRESCALE{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_s2.vld     <= 1'b0;
			cell_s2.arrived <= dist_sq < {1'b0, rsq_s1};
			cell_s2.zero    <= (dr_s1 == '0) && (dc_s1 == '0);
			cell_s2.heading <= heading_s1;
			if (dr_s1 < 0) begin
				cell_s2.x <= -x_scaled;
				cell_s2.y <= -y_scaled;
				cell_s2.z <= (dc_s1 >= 0) ? PI_Q24 : -PI_Q24;
			end else begin
				cell_s2.x <= x_scaled;
				cell_s2.y <= y_scaled;
				cell_s2.z <= '0;
			end
		end
	end

	always_comb begin
		cell_out     = cell_s2;
		cell_out.vld = vld_s2;
	end

endmodule

// File: rtl/wpst_cordic_cell.sv
// ----------------------------------------------------------------------------
// wpst_cordic_cell: one vectoring micro-rotation
// Rotates toward the x axis by atan(2^-SHIFT) and hands the result on.
// ----------------------------------------------------------------------------
module wpst_cordic_cell import wpst_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  wpst_cell_t cell_in,
	output wpst_cell_t cell_out
);

	localparam logic signed [Z_W-1:0] ATAN = wpst_atan(SHIFT);

	logic                   vld_q;
	wpst_cell_t             cell_d;
	wpst_cell_t             cell_q;
	logic signed [XY_W-1:0] xs, ys;

	assign xs = cell_in.x >>> SHIFT;
	assign ys = cell_in.y >>> SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= cell_in.vld;
		end
	end

	// Direction follows the sign of y
	always_comb begin
		cell_d = cell_in;
		if (cell_in.y >= 0) begin
			cell_d.x = cell_in.x + ys;
			cell_d.y = cell_in.y - xs;
			cell_d.z = cell_in.z + ATAN;
		end else begin
			cell_d.x = cell_in.x - ys;
			cell_d.y = cell_in.y + xs;
			cell_d.z = cell_in.z - ATAN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= cell_d;
		end
	end

	always_comb begin
		cell_out     = cell_q;
		cell_out.vld = vld_q;
	end

endmodule

// File: rtl/wpst_back.sv
// ----------------------------------------------------------------------------
// wpst_back: heading error and steering decision
// Rounds the bearing to Q12, wraps the error into plus or minus pi once,
// picks stop, turn or drive and holds the result in the output register.
// ----------------------------------------------------------------------------
module wpst_back import wpst_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  wpst_cell_t               cell_in,
	input  logic [TOL_W-1:0]         heading_tol,
	input  logic [SPEED_W-1:0]       turn_rate,
	input  logic [SPEED_W-1:0]       drive_speed,
	output logic                     out_vld,
	output logic [SPEED_W-1:0]       linear_speed,
	output logic signed [ANG_W-1:0]  angular_speed,
	output logic                     arrived,
	output logic signed [HEAD_W-1:0] heading_error
);

	logic signed [Z_W-1:0]   z_rnd;
	logic signed [ERR_W-1:0] bearing;

	logic                    vld_s3, arrived_s3;
	logic signed [ERR_W-1:0] err_s3;
	logic                    vld_s4, arrived_s4;
	logic signed [ERR_W-1:0] err_s4;
	logic signed [ERR_W-1:0] mag;

	// Stage 3: round bearing, subtract heading
	always_comb begin
		z_rnd   = cell_in.z + ROUND_Q12;
		bearing = cell_in.zero ? '0 : ERR_W'(z_rnd >>> 12);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s3 <= cell_in.vld;
			vld_s4 <= vld_s3;
			out_vld <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			arrived_s3 <= cell_in.arrived;
			err_s3     <= bearing - ERR_W'(cell_in.heading);
		end
	end

	// Stage 4: single wrap into plus or minus pi
	always_ff @(posedge clk) begin
		if (en) begin
			arrived_s4 <= arrived_s3;
			if (err_s3 > PI_Q12) begin
				err_s4 <= err_s3 - TWO_PI_Q12;
			end else if (err_s3 < -PI_Q12) begin
				err_s4 <= err_s3 + TWO_PI_Q12;
			end else begin
				err_s4 <= err_s3;
			end
		end
	end

	// Output register: stop, turn or drive
	assign mag = (err_s4 < 0) ? -err_s4 : err_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			arrived <= arrived_s4;
			if (arrived_s4) begin
				linear_speed  <= '0;
				angular_speed <= '0;
				heading_error <= '0;
			end else begin
				heading_error <= HEAD_W'(err_s4);
				if (mag > $signed({{(ERR_W-TOL_W){1'b0}}, heading_tol})) begin
					linear_speed  <= '0;
					angular_speed <= (err_s4 > 0) ? $signed({1'b0, turn_rate})
					                              : -$signed({1'b0, turn_rate});
				end else begin
					linear_speed  <= drive_speed;
					angular_speed <= '0;
				end
			end
		end
	end

endmodule

// File: rtl/waypoint_heading_steer_top.sv
// ----------------------------------------------------------------------------
// waypoint_heading_steer_top: turn-then-drive steering toward a grid waypoint
// Pipeline: two front stages, one cell per CORDIC micro-rotation, two error
// stages and the output register lie between input transaction and result.
// Throughput: one transaction per cycle; the whole pipe holds only while a
// result waits at the output. Reset clears all valid flags and loads the
// register defaults (radius 10, tolerance 1024, turn 30, drive 50).
// ----------------------------------------------------------------------------
module waypoint_heading_steer_top import wpst_pkg::*; #(
	parameter int MAP_DIM       = 1024,
	parameter int CORDIC_STAGES = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	// tgt_row[9:0], tgt_col[19:10], pose_row[29:20], pose_col[39:30],
	// pose_heading[54:40], zero pad[55]
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [55:0]  s_axis_tdata,
	// linear_speed[9:0], angular_speed[20:10], heading_error[35:21],
	// zero pad[39:36]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [39:0]  m_axis_tdata,
	// arrived[0]
	output logic         m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_addr,
	input  logic [CFG_W-1:0] cfg_data
);

	logic                     adv;
	logic [COORD_W-1:0]       radius_q;
	logic [TOL_W-1:0]         tol_q;
	logic [SPEED_W-1:0]       turn_q;
	logic [SPEED_W-1:0]       drive_q;

	wpst_cell_t               chain [0:CORDIC_STAGES];

	logic [SPEED_W-1:0]       lin;
	logic signed [ANG_W-1:0]  ang;
	logic                     arr;
	logic signed [HEAD_W-1:0] herr;

	// Pipeline moves whenever the output register is free or being drained
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready     = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 10'd10;
			tol_q    <= 14'd1024;
			turn_q   <= 10'd30;
			drive_q  <= 10'd50;
		end else if (cfg_valid && cfg_ready) begin
			case (wpst_reg_t'(cfg_addr))
				REG_ARRIVE_RADIUS: radius_q <= cfg_data[COORD_W-1:0];
				REG_HEADING_TOL:   tol_q    <= cfg_data[TOL_W-1:0];
				REG_TURN_RATE:     turn_q   <= cfg_data[SPEED_W-1:0];
				REG_DRIVE_SPEED:   drive_q  <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	wpst_front #(
		.MAP_DIM (MAP_DIM)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (adv),
		.in_vld        (s_axis_tvalid),
		.tgt_row       (s_axis_tdata[9:0]),
		.tgt_col       (s_axis_tdata[19:10]),
		.pose_row      (s_axis_tdata[29:20]),
		.pose_col      (s_axis_tdata[39:30]),
		.pose_heading  (s_axis_tdata[54:40]),
		.arrive_radius (radius_q),
		.cell_out      (chain[0])
	);

	// Chain of CORDIC cells, one micro-rotation each
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		wpst_cordic_cell #(
			.SHIFT (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.cell_in  (chain[i]),
			.cell_out (chain[i+1])
		);
	end

	wpst_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (adv),
		.cell_in       (chain[CORDIC_STAGES]),
		.heading_tol   (tol_q),
		.turn_rate     (turn_q),
		.drive_speed   (drive_q),
		.out_vld       (m_axis_tvalid),
		.linear_speed  (lin),
		.angular_speed (ang),
		.arrived       (arr),
		.heading_error (herr)
	);

	assign m_axis_tdata = {4'b0, herr, ang, lin};
	assign m_axis_tuser = arr;

endmodule

// File: rtl/wpst_checker.sv
// ----------------------------------------------------------------------------
// wpst_checker: port-level checks for the waypoint steering block
// Watches the output stream and the input ready over time.
// ----------------------------------------------------------------------------
module wpst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("output changed while stalled");

	// Input side only stalls behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// Arrival means stop and zero error
	a_arrive_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[35:0] == 36'd0)
		else $error("arrival without stop command");

	// Never turn and drive at once
	a_turn_or_drive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[9:0] == 10'd0 || m_axis_tdata[20:10] == 11'd0)
		else $error("turn and drive commanded together");

	// A turn needs a nonzero heading error
	a_turn_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[20:10] != 11'd0 |-> m_axis_tdata[35:21] != 15'd0)
		else $error("turn with zero heading error");

endmodule

bind waypoint_heading_steer_top wpst_checker u_wpst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// File: dv/waypoint_heading_steer_checker.sv
// ----------------------------------------------------------------------------
// waypoint_heading_steer_checker: steering command scoreboard
// Watches the config, tick and command channels, keeps its own copy of the
// registers, predicts the command for every accepted tick and compares each
// accepted command with the oldest prediction.
// ----------------------------------------------------------------------------
module waypoint_heading_steer_checker import wpst_pkg::*; #(
	parameter int MAP_DIM       = 1024,
	parameter int CORDIC_STAGES = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	input  logic [55:0]      s_axis_tdata,
	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	input  logic [39:0]      m_axis_tdata,
	input  logic             m_axis_tuser,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [1:0]       cfg_addr,
	input  logic [CFG_W-1:0] cfg_data,
	output int               outstanding,
	output int               fail_count,
	output int               result_total,
	output int               arrival_total,
	output int               turn_total
);

	typedef struct packed {
		logic [SPEED_W-1:0]      lin;
		logic signed [ANG_W-1:0] ang;
		logic                    arrived;
		logic signed [HEAD_W-1:0] err;
	} steer_cmd_t;

	// register shadow
	logic [COORD_W-1:0] cfg_radius;
	logic [TOL_W-1:0]   cfg_tol;
	logic [SPEED_W-1:0] cfg_turn;
	logic [SPEED_W-1:0] cfg_drive;

	steer_cmd_t cmd_expected[$];
	steer_cmd_t cmd_want;
	steer_cmd_t cmd_got;

	// atan(2^-i) in Q24, built from the real arctangent
	longint atan_q24_lut [TABLE_LEN];

	initial begin
		for (int i = 0; i < TABLE_LEN; i++) begin
			atan_q24_lut[i] = longint'($atan(1.0 / (2.0 ** i)) * 16777216.0);
		end
	end

	function automatic longint coord_clamp(input logic [COORD_W-1:0] c);
		return (c > MAP_DIM - 1) ? longint'(MAP_DIM - 1) : longint'(c);
	endfunction

	// Steering command for one tick under the current register shadow
	function automatic steer_cmd_t steer_predict(input logic [55:0] d);
		longint dr, dc, heading, x, y, z, xs, ys, bear, err, mag, lin, ang, r;
		steer_cmd_t c;
		dr = coord_clamp(d[9:0]) - coord_clamp(d[29:20]);
		dc = coord_clamp(d[19:10]) - coord_clamp(d[39:30]);
		heading = longint'($signed(d[54:40]));
		r = longint'(cfg_radius);
		c = '0;
		lin = 0;
		ang = 0;
		if (dr * dr + dc * dc < r * r) begin
			c.arrived = 1'b1;
			return c;
		end
		// goal bearing atan2(dc, dr) by vectoring rotations
		if (dr == 0 && dc == 0) begin
			bear = 0;
		end else begin
			x = dr * (longint'(1) << PRESCALE);
			y = dc * (longint'(1) << PRESCALE);
			z = 0;
			// left half plane: pre-rotate by pi
			if (dr < 0) begin
				z = (dc >= 0) ? longint'(PI_Q24) : -longint'(PI_Q24);
				x = -x;
				y = -y;
			end
			for (int i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + atan_q24_lut[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - atan_q24_lut[i];
				end
			end
			bear = (z + longint'(ROUND_Q12)) >>> 12;
		end
		// heading error, wrapped a single time
		err = bear - heading;
		mag = (err < 0) ? -err : err;
		if (mag > longint'(PI_Q12)) begin
			err = (err > 0) ? err - longint'(TWO_PI_Q12) : err + longint'(TWO_PI_Q12);
			mag = (err < 0) ? -err : err;
		end
		if (mag > longint'(cfg_tol)) begin
			ang = (err > 0) ? longint'(cfg_turn) : -longint'(cfg_turn);
		end else begin
			lin = longint'(cfg_drive);
		end
		c.lin = lin[SPEED_W-1:0];
		c.ang = ang[ANG_W-1:0];
		c.err = err[HEAD_W-1:0];
		return c;
	endfunction

	// Channel monitor: commands are checked before new ticks are queued
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_radius = 10'd10;
			cfg_tol = 14'd1024;
			cfg_turn = 10'd30;
			cfg_drive = 10'd50;
			cmd_expected.delete();
			outstanding = 0;
			fail_count = 0;
			result_total = 0;
			arrival_total = 0;
			turn_total = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (wpst_reg_t'(cfg_addr))
					REG_ARRIVE_RADIUS: cfg_radius = cfg_data[COORD_W-1:0];
					REG_HEADING_TOL:   cfg_tol = cfg_data[TOL_W-1:0];
					REG_TURN_RATE:     cfg_turn = cfg_data[SPEED_W-1:0];
					REG_DRIVE_SPEED:   cfg_drive = cfg_data[SPEED_W-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				cmd_got.lin = m_axis_tdata[9:0];
				cmd_got.ang = m_axis_tdata[20:10];
				cmd_got.err = m_axis_tdata[35:21];
				cmd_got.arrived = m_axis_tuser;
				if (cmd_expected.size() == 0) begin
					$error("unexpected command transaction: no tick pending");
					fail_count++;
				end else begin
					cmd_want = cmd_expected.pop_front();
					result_total++;
					if (cmd_want.arrived) arrival_total++;
					if (cmd_want.ang != 0) turn_total++;
					if (cmd_got.lin !== cmd_want.lin) begin
						$error("linear_speed: expected %0d, got %0d", cmd_want.lin, cmd_got.lin);
						fail_count++;
					end
					if (cmd_got.ang !== cmd_want.ang) begin
						$error("angular_speed: expected %0d, got %0d",
							cmd_want.ang, cmd_got.ang);
						fail_count++;
					end
					if (cmd_got.err !== cmd_want.err) begin
						$error("heading_error: expected %0d, got %0d",
							cmd_want.err, cmd_got.err);
						fail_count++;
					end
					if (cmd_got.arrived !== cmd_want.arrived) begin
						$error("arrived: expected %0d, got %0d",
							cmd_want.arrived, cmd_got.arrived);
						fail_count++;
					end
					if (m_axis_tdata[39:36] !== 4'd0) begin
						$error("tdata pad: expected 0, got %0h", m_axis_tdata[39:36]);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				cmd_expected.push_back(steer_predict(s_axis_tdata));
			end
			outstanding = cmd_expected.size();
		end
	end

endmodule

// File: dv/waypoint_heading_steer_top_tb.sv
// ----------------------------------------------------------------------------
// waypoint_heading_steer_top_tb: stimulus and verdict for the steering block
// Directed ticks on arrival, turn, drive and wrap corners, then random ticks
// under several register settings with random stalls on both sides, a long
// output hold-off and a full drain; the checker scores every command.
// ----------------------------------------------------------------------------
module waypoint_heading_steer_top_tb;
	import wpst_pkg::*;

	localparam int MAP_DIM       = 1024;
	localparam int CORDIC_STAGES = 14;
	localparam int QUIET_LIMIT   = 3000;
	localparam int PHASE_TICKS   = 135;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [55:0]      s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [39:0]      m_axis_tdata;
	logic             m_axis_tuser;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [1:0]       cfg_addr;
	logic [CFG_W-1:0] cfg_data;

	int outstanding;
	int fail_count;
	int result_total;
	int arrival_total;
	int turn_total;

	// stall control and register mirror for aiming stimulus
	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold;
	int cur_radius;
	int cur_tol;
	int ticks_sent;
	int setting_count;
	int quiet_cycles;

	waypoint_heading_steer_top #(
		.MAP_DIM      (MAP_DIM),
		.CORDIC_STAGES(CORDIC_STAGES)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data)
	);

	waypoint_heading_steer_checker #(
		.MAP_DIM      (MAP_DIM),
		.CORDIC_STAGES(CORDIC_STAGES)
	) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.outstanding  (outstanding),
		.fail_count   (fail_count),
		.result_total (result_total),
		.arrival_total(arrival_total),
		.turn_total   (turn_total)
	);

	always #10 clk = ~clk;

	// Command receiver: random stalls, or a long hold-off when requested
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else begin
			m_axis_tready <= (int'($urandom_range(99)) >= rx_idle_pct);
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: %0d cycles without a transaction", quiet_cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic logic [55:0] pack_tick(input int gr, input int gc, input int pr,
			input int pc, input int hdg);
		return {1'b0, 15'(hdg), 10'(pc), 10'(pr), 10'(gc), 10'(gr)};
	endfunction

	function automatic int to_cell(input int v);
		return (v < 0) ? 0 : (v > MAP_DIM - 1) ? MAP_DIM - 1 : v;
	endfunction

	// Random tick: full-range, near-goal or axis-aligned geometry, with the
	// heading aimed at the tolerance or wrap edges much of the time
	function automatic logic [55:0] random_tick();
		int gr, gc, pr, pc, span, aim, pick;
		pr = int'($urandom_range(MAP_DIM - 1));
		pc = int'($urandom_range(MAP_DIM - 1));
		pick = int'($urandom_range(99));
		if (pick < 35) begin
			gr = int'($urandom_range(MAP_DIM - 1));
			gc = int'($urandom_range(MAP_DIM - 1));
		end else if (pick < 75) begin
			span = cur_radius + 4;
			gr = to_cell(pr + int'($urandom_range(2 * span)) - span);
			gc = to_cell(pc + int'($urandom_range(2 * span)) - span);
		end else if ($urandom_range(1)) begin
			gr = pr;
			gc = int'($urandom_range(MAP_DIM - 1));
		end else begin
			gr = int'($urandom_range(MAP_DIM - 1));
			gc = pc;
		end
		pick = int'($urandom_range(99));
		if (pick < 45) begin
			aim = int'($urandom_range(25736)) - 12868;
		end else if (pick < 60) begin
			aim = int'($urandom());
		end else if (pick < 90) begin
			aim = int'($atan2(real'(gc - pc), real'(gr - pr)) * 4096.0);
			aim = aim + int'($urandom_range(6)) - 3;
			case ($urandom_range(3))
				0: aim = aim + cur_tol;
				1: aim = aim - cur_tol;
				2: aim = aim + 12868;
				default: aim = aim - 12868;
			endcase
		end else begin
			case ($urandom_range(4))
				0: aim = -16384;
				1: aim = 16383;
				2: aim = 12868;
				3: aim = -12868;
				default: aim = 0;
			endcase
		end
		return pack_tick(gr, gc, pr, pc, aim);
	endfunction

	// One tick transaction; tvalid stays high when the next follows at once
	task automatic send_tick(input logic [55:0] d);
		int gap;
		gap = 0;
		while (gap < 40 && int'($urandom_range(99)) < tx_idle_pct) gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_reg(input wpst_reg_t idx, input int val);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= CFG_W'(val);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Register update, only once the pipe has emptied
	task automatic set_config(input int radius, input int tol, input int turn,
			input int drive);
		drain_results();
		write_reg(REG_ARRIVE_RADIUS, radius);
		write_reg(REG_HEADING_TOL, tol);
		write_reg(REG_TURN_RATE, turn);
		write_reg(REG_DRIVE_SPEED, drive);
		cfg_valid <= 1'b0;
		cur_radius = radius;
		cur_tol = tol;
		setting_count++;
	endtask

	task automatic random_config();
		set_config(($urandom_range(3) == 0) ? int'($urandom_range(1023))
				: int'($urandom_range(40)),
			int'($urandom_range(12868)), int'($urandom_range(1000)),
			int'($urandom_range(1000)));
	endtask

	// Random phase; optional output hold-off and mid-phase drain
	task automatic run_phase(input int tx_pct, input int rx_pct, input bit hold,
			input bit pause);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		if (hold) rx_hold = 300;
		for (int i = 0; i < PHASE_TICKS; i++) begin
			if (pause && i == PHASE_TICKS / 2) drain_results();
			send_tick(random_tick());
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_addr = REG_ARRIVE_RADIUS;
		cfg_data = '0;
		tx_idle_pct = 23;
		rx_idle_pct = 75;
		rx_hold = 0;
		cur_radius = 10;
		cur_tol = 1024;
		ticks_sent = 0;
		setting_count = 1;
		quiet_cycles = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset registers (radius 10, tolerance 1024)
		send_tick(pack_tick(0, 0, 0, 0, 0));
		send_tick(pack_tick(1023, 1023, 1023, 1023, 16383));
		send_tick(pack_tick(1023, 1023, 0, 0, 0));
		send_tick(pack_tick(0, 0, 1023, 1023, 0));
		send_tick(pack_tick(600, 500, 500, 500, 0));
		// goal straight behind, then headings that cancel or wrap
		send_tick(pack_tick(400, 500, 500, 500, 0));
		send_tick(pack_tick(400, 500, 500, 500, 12868));
		send_tick(pack_tick(400, 500, 500, 500, -12868));
		// heading beyond plus or minus pi
		send_tick(pack_tick(500, 400, 500, 500, 16383));
		send_tick(pack_tick(500, 600, 500, 500, -16384));
		// arrival radius edge: distance squared 100 vs 97
		send_tick(pack_tick(506, 508, 500, 500, 0));
		send_tick(pack_tick(509, 504, 500, 500, 0));
		// tolerance edge
		send_tick(pack_tick(510, 500, 500, 500, 1024));
		send_tick(pack_tick(510, 500, 500, 500, 1025));
		send_tick(pack_tick(510, 500, 500, 500, -1025));
		send_tick(pack_tick(0, 1023, 1023, 0, -12868));

		// zero radius and zero tolerance: goal on the robot cell
		set_config(0, 0, 1000, 1000);
		send_tick(pack_tick(300, 300, 300, 300, 0));
		send_tick(pack_tick(300, 300, 300, 300, 1));
		send_tick(pack_tick(300, 300, 300, 300, -1));
		send_tick(pack_tick(800, 300, 300, 300, 0));
		send_tick(pack_tick(0, 1023, 1023, 1023, 12868));

		// widest radius and tolerance, zero speeds
		set_config(1023, 12868, 0, 0);
		send_tick(pack_tick(0, 0, 1023, 1023, 0));
		send_tick(pack_tick(0, 0, 700, 700, 0));
		send_tick(pack_tick(1023, 0, 0, 1023, -12868));

		// random ticks: sender idles lightly, receiver heavily
		set_config(0, 0, 1000, 1000);
		run_phase(23, 75, 1'b0, 1'b0);
		random_config();
		run_phase(23, 75, 1'b0, 1'b0);
		// then the other way round, with a long output hold-off and a drain
		random_config();
		run_phase(75, 23, 1'b1, 1'b0);
		random_config();
		run_phase(75, 23, 1'b0, 1'b1);
		// then no idling at all
		random_config();
		run_phase(0, 0, 1'b0, 1'b0);
		set_config(10, 1024, 30, 50);
		run_phase(0, 0, 1'b0, 1'b0);

		drain_results();
		repeat (CORDIC_STAGES + 10) @(posedge clk);
		$display("coverage: %0d ticks sent under %0d register settings", ticks_sent,
			setting_count);
		$display("coverage: %0d commands checked, %0d arrivals, %0d nonzero turns",
			result_total, arrival_total, turn_total);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
